@@ rtl/core/dbie_pkg.sv @@
package dbie_pkg;

  // Pin report codes.
  localparam logic [1:0] PIN_NONE = 2'd0;
  localparam logic [1:0] PIN_ON   = 2'd1;
  localparam logic [1:0] PIN_OFF  = 2'd2;

  // Alarm modes.
  localparam logic [1:0] ALARM_BOTH      = 2'd0;
  localparam logic [1:0] ALARM_RISE_ONLY = 2'd1;
  localparam logic [1:0] ALARM_FALL_ONLY = 2'd2;
  localparam logic [1:0] ALARM_NONE      = 2'd3;

  // Register indexes on the configuration port.
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = 5;
  localparam logic [RegIdxW-1:0] REG_ENABLED       = 3'd0;
  localparam logic [RegIdxW-1:0] REG_RISE_COUNT    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_FALL_COUNT    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_HIGH_PRIORITY = 3'd3;
  localparam logic [RegIdxW-1:0] REG_ALARM_MODE    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_POINT_ADDRESS = 3'd5;
  localparam logic [RegIdxW-1:0] REG_SENSOR_ID     = 3'd6;

  typedef enum logic [1:0] {
    CAUSE_RISE = 2'd0,
    CAUSE_FALL = 2'd1,
    CAUSE_NONE = 2'd3
  } cause_e;

  typedef struct packed {
    logic       enabled;
    logic [7:0] rise_count;
    logic [7:0] fall_count;
    logic       high_priority;
    logic [1:0] alarm_mode;
    logic [7:0] point_address;
    logic [7:0] sensor_id;
  } cfg_t;

  typedef struct packed {
    logic       cause;
    logic       level;
    logic [7:0] event_address;
    logic [7:0] event_sensor;
  } evt_t;

endpackage

@@ rtl/core/dbie_regs.sv @@
module dbie_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dbie_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output dbie_pkg::cfg_t             cfg_o
);
  import dbie_pkg::*;

  cfg_t               cfg_q;
  logic [RegIdxW-1:0] idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled       <= 1'b0;
      cfg_q.rise_count    <= 8'd1;
      cfg_q.fall_count    <= 8'd1;
      cfg_q.high_priority <= 1'b0;
      cfg_q.alarm_mode    <= ALARM_NONE;
      cfg_q.point_address <= 8'd0;
      cfg_q.sensor_id     <= 8'd0;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLED:       cfg_q.enabled       <= pwdata[0];
        REG_RISE_COUNT:    cfg_q.rise_count    <= pwdata[7:0];
        REG_FALL_COUNT:    cfg_q.fall_count    <= pwdata[7:0];
        REG_HIGH_PRIORITY: cfg_q.high_priority <= pwdata[0];
        REG_ALARM_MODE:    cfg_q.alarm_mode    <= pwdata[1:0];
        REG_POINT_ADDRESS: cfg_q.point_address <= pwdata[7:0];
        REG_SENSOR_ID:     cfg_q.sensor_id     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (idx)
      REG_ENABLED:       prdata = {31'd0, cfg_q.enabled};
      REG_RISE_COUNT:    prdata = {24'd0, cfg_q.rise_count};
      REG_FALL_COUNT:    prdata = {24'd0, cfg_q.fall_count};
      REG_HIGH_PRIORITY: prdata = {31'd0, cfg_q.high_priority};
      REG_ALARM_MODE:    prdata = {30'd0, cfg_q.alarm_mode};
      REG_POINT_ADDRESS: prdata = {24'd0, cfg_q.point_address};
      REG_SENSOR_ID:     prdata = {24'd0, cfg_q.sensor_id};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/dbie_core.sv @@
module dbie_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dbie_pkg::cfg_t cfg_i,
  input  logic           req_valid_i,
  input  logic [1:0]     pin_code_i,
  output logic           req_stall_o,
  input  logic           hold_i,
  output logic           evt_valid_o,
  output dbie_pkg::evt_t evt_o
);
  import dbie_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_code_q;
  logic       accept, advance;

  logic       rise_armed_q, rise_armed_d;
  logic       fall_armed_q, fall_armed_d;
  logic [7:0] rise_timer_q, rise_timer_d;
  logic [7:0] fall_timer_q, fall_timer_d;
  logic       first_fall_q, first_fall_d;
  cause_e     last_cause_q, last_cause_d;
  logic       emit;
  evt_t       evt;

  assign req_stall_o = s1_valid_q & hold_i;
  assign accept      = req_valid_i & ~req_stall_o;
  assign advance     = s1_valid_q & ~hold_i;
  assign s1_valid_d  = accept | (s1_valid_q & hold_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_code_q <= pin_code_i;
    end
  end

  // One tick of the debounce timers for the request held in stage one.
  always_comb begin
    logic allow;
    rise_armed_d = rise_armed_q;
    fall_armed_d = fall_armed_q;
    rise_timer_d = rise_timer_q;
    fall_timer_d = fall_timer_q;
    first_fall_d = first_fall_q;
    last_cause_d = last_cause_q;
    emit         = 1'b0;
    evt.cause         = 1'b0;
    evt.level         = 1'b0;
    evt.event_address = cfg_i.point_address;
    evt.event_sensor  = cfg_i.sensor_id;
    allow        = 1'b0;
    if (advance && cfg_i.enabled) begin
      if (s1_code_q == PIN_ON) begin
        rise_armed_d = 1'b1;
        fall_armed_d = 1'b0;
        rise_timer_d = cfg_i.rise_count;
      end else if (s1_code_q == PIN_OFF) begin
        fall_armed_d = 1'b1;
        rise_armed_d = 1'b0;
        fall_timer_d = cfg_i.fall_count;
      end

      if (rise_armed_d) begin
        rise_timer_d = rise_timer_d - 8'd1;
        if (rise_timer_d == 8'd0) begin
          allow = cfg_i.high_priority &&
                  (cfg_i.alarm_mode == ALARM_BOTH || cfg_i.alarm_mode == ALARM_RISE_ONLY);
          if (last_cause_d != CAUSE_RISE) begin
            last_cause_d = CAUSE_RISE;
            if (allow) begin
              emit      = 1'b1;
              evt.cause = 1'b0;
              evt.level = 1'b1;
            end
          end
          rise_armed_d = 1'b0;
        end
      end

      if (fall_armed_d) begin
        fall_timer_d = fall_timer_d - 8'd1;
        if (fall_timer_d == 8'd0) begin
          allow = cfg_i.high_priority &&
                  (cfg_i.alarm_mode == ALARM_BOTH || cfg_i.alarm_mode == ALARM_FALL_ONLY);
          // The first fall expiry after reset is swallowed without a record.
          if (first_fall_q && !emit && last_cause_d != CAUSE_FALL) begin
            last_cause_d = CAUSE_FALL;
            if (allow) begin
              emit      = 1'b1;
              evt.cause = 1'b1;
              evt.level = 1'b0;
            end
          end
          fall_armed_d = 1'b0;
          first_fall_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_armed_q <= 1'b0;
      fall_armed_q <= 1'b0;
      rise_timer_q <= 8'd0;
      fall_timer_q <= 8'd0;
      first_fall_q <= 1'b0;
      last_cause_q <= CAUSE_NONE;
    end else begin
      rise_armed_q <= rise_armed_d;
      fall_armed_q <= fall_armed_d;
      rise_timer_q <= rise_timer_d;
      fall_timer_q <= fall_timer_d;
      first_fall_q <= first_fall_d;
      last_cause_q <= last_cause_d;
    end
  end

  assign evt_valid_o = emit;
  assign evt_o       = evt;

  a_arm_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rise_armed_q && fall_armed_q))
    else $error("rise and fall timers armed together");

  a_first_fall_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_fall_q |=> first_fall_q)
    else $error("first fall flag cleared after being set");

  a_emit_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_o |-> (advance && cfg_i.enabled && cfg_i.high_priority))
    else $error("event produced without an enabled high priority tick");

  a_fall_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_valid_o && evt_o.cause) |-> first_fall_q)
    else $error("fall event reported before first fall was swallowed");

endmodule

@@ rtl/core/dbie_outbuf.sv @@
module dbie_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dbie_pkg::evt_t evt_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           stall_i,
  output dbie_pkg::evt_t evt_o
);
  import dbie_pkg::*;

  evt_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o & ~stall_i;
  assign evt_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= evt_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full output buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  a_ptrs_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("buffer pointers disagree with count");

endmodule

@@ rtl/core/debounced_binary_input_events.sv @@
// Debounced binary input with event report. Each request is one scan tick
// carrying a pin code; the block accepts one request per clock while
// in_stall_o is low. The request passes an input register, then one pass of
// timer logic updates the debounce state and writes any event into a
// two-entry output buffer, from which it is presented on the output, so
// output stall only backs up into the input once that buffer is full.
// Configure through the APB port while no requests are in flight.
module debounced_binary_input_events (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dbie_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 pin_code_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       cause_o,
  output logic                       level_o,
  output logic [7:0]                 event_address_o,
  output logic [7:0]                 event_sensor_o
);
  import dbie_pkg::*;

  cfg_t cfg;
  evt_t core_evt, buf_evt;
  logic core_valid, buf_full;

  dbie_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dbie_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (in_valid_i),
    .pin_code_i  (pin_code_i),
    .req_stall_o (in_stall_o),
    .hold_i      (buf_full),
    .evt_valid_o (core_valid),
    .evt_o       (core_evt)
  );

  dbie_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_valid),
    .evt_i   (core_evt),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .evt_o   (buf_evt)
  );

  assign cause_o         = buf_evt.cause;
  assign level_o         = buf_evt.level;
  assign event_address_o = buf_evt.event_address;
  assign event_sensor_o  = buf_evt.event_sensor;

endmodule
